// File: rtl/gbu_pkg.sv
// Shared types and constants for the glyph bitmap unpacker.
// No dependencies; the top level, front end, queue and back end import this package.
package gbu_pkg;

    // Defaults for the glyph width parameter and the queue depth
    localparam int DEF_MAX_GLYPH_WIDTH = 64;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Pixel count per command covers the widest legal glyph row (64)
    localparam int PIX_CNT_W = 7;
    localparam int IDX_W     = PIX_CNT_W - 1;

    // Register indexes
    localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
    localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd1;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;
    localparam logic [1:0] REG_ROW_STRIDE   = 2'd3;

    // Pixel modes
    localparam logic [1:0] MODE_MONO_ROW    = 2'd0;
    localparam logic [1:0] MODE_NIBBLE      = 2'd1;
    localparam logic [1:0] MODE_RAW         = 2'd2;
    localparam logic [1:0] MODE_MONO_STRIDE = 2'd3;

    // Reset values of the registers
    localparam logic [1:0] RST_PIXEL_MODE   = MODE_MONO_ROW;
    localparam logic [6:0] RST_GLYPH_WIDTH  = 7'd8;
    localparam logic [7:0] RST_GLYPH_HEIGHT = 8'd8;
    localparam logic [7:0] RST_ROW_STRIDE   = 8'd1;

    // One classified input byte: what the back end has to emit for it
    typedef struct packed {
        logic [7:0]           data;
        logic [1:0]           mode;
        logic [PIX_CNT_W-1:0] count;     // pixels to emit, at least one
        logic                 row_end;   // last pixel closes a row
        logic                 last_row;  // row is the glyph's last one
    } cmd_t;

endpackage

// File: rtl/gbu_stream_if.sv
// Valid/ready stream interfaces for the glyph bitmap unpacker.
// No dependencies.
interface gbu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface gbu_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       row_end;
    logic       glyph_end;
    logic       last_of_input;

    modport source (output valid, output pixel, output row_end, output glyph_end,
                    output last_of_input, input ready);
    modport sink   (input valid, input pixel, input row_end, input glyph_end,
                    input last_of_input, output ready);
endinterface

// File: rtl/glyph_bitmap_unpacker.sv
// Glyph bitmap unpacker: packed glyph bytes in, 8-bit grayscale pixels out.
// Path: command queue, then back end command register, then output register.
// The back end gives one pixel per cycle while the sink is ready; a byte holds it
// until all its pixels are out (up to the glyph width in one-bit byte-per-row mode).
// Input is taken every cycle while the command queue has room.
// Reset: counters and handshakes cleared, registers back to their defaults.
module glyph_bitmap_unpacker
    import gbu_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [7:0]  wr_data,
    gbu_byte_if.sink    byte_stream,
    gbu_pixel_if.source pixel_stream
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_push_cmd, q_pop_cmd;

    gbu_front #(
        .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .byte_stream(byte_stream),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_push_cmd (q_push_cmd)
    );

    gbu_cmd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(q_push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .pop_cmd (q_pop_cmd),
        .empty   (q_empty)
    );

    gbu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop_cmd   (q_pop_cmd),
        .q_pop       (q_pop),
        .pixel_stream(pixel_stream)
    );

endmodule

// File: rtl/gbu_front.sv
// Front end: configuration registers, row/column counters and byte classification.
// Depends on gbu_pkg and gbu_byte_if; pushes one command per pixel-producing byte.
module gbu_front
    import gbu_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [7:0]  wr_data,
    gbu_byte_if.sink    byte_stream,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_push_cmd
);

    localparam int COL_W = $clog2(MAX_GLYPH_WIDTH);
    localparam logic [6:0] W_MAX = 7'(MAX_GLYPH_WIDTH);

    logic [1:0]       mode_reg;
    logic [6:0]       width_reg;
    logic [7:0]       height_reg;
    logic [7:0]       stride_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [7:0]       row_reg, row_next;
    logic [7:0]       bir_reg, bir_next;

    logic       accept;
    logic [6:0] w_eff;
    logic [7:0] h_eff;
    logic [7:0] w_plus7;
    logic [3:0] need;
    logic [7:0] s_base;
    logic [7:0] s_eff;
    logic [7:0] col_ext;
    logic       last_row;
    logic       finish;
    logic       rend;
    logic [PIX_CNT_W-1:0] cnt;
    logic [6:0] base;
    logic [6:0] rem;
    logic [8:0] row_inc;

    assign byte_stream.ready = !q_full;
    assign accept = byte_stream.valid && !q_full;

    always_comb
    begin
        if (width_reg == 7'd0)
            w_eff = 7'd1;
        else if (width_reg > W_MAX)
            w_eff = W_MAX;
        else
            w_eff = width_reg;
        h_eff   = (height_reg == 8'd0) ? 8'd1 : height_reg;
        w_plus7 = {1'b0, w_eff} + 8'd7;
        need    = w_plus7[6:3];
        s_base  = (stride_reg == 8'd0) ? 8'd1 : stride_reg;
        s_eff   = (s_base < {4'd0, need}) ? {4'd0, need} : s_base;
        col_ext = 8'(col_reg);
        row_inc = {1'b0, row_reg} + 9'd1;
        last_row = row_inc >= {1'b0, h_eff};
        base    = {1'b0, bir_reg[2:0], 3'b000};
        rem     = w_eff - base;
    end

    // Classify the byte: how many pixels it yields and whether it closes the row
    always_comb
    begin
        cnt    = '0;
        rend   = 1'b0;
        finish = 1'b0;
        case (mode_reg)
            MODE_MONO_ROW:
            begin
                cnt    = PIX_CNT_W'(w_eff);
                rend   = 1'b1;
                finish = 1'b1;
            end
            MODE_NIBBLE:
            begin
                if (col_ext + 8'd1 >= {1'b0, w_eff})
                begin
                    cnt  = PIX_CNT_W'(1);
                    rend = 1'b1;
                end
                else
                begin
                    cnt  = PIX_CNT_W'(2);
                    rend = col_ext + 8'd2 >= {1'b0, w_eff};
                end
                finish = rend;
            end
            MODE_RAW:
            begin
                cnt    = PIX_CNT_W'(1);
                rend   = col_ext + 8'd1 >= {1'b0, w_eff};
                finish = rend;
            end
            default:
            begin
                if (bir_reg < {4'd0, need})
                begin
                    cnt  = (rem > 7'd8) ? PIX_CNT_W'(8) : PIX_CNT_W'(rem);
                    rend = rem <= 7'd8;
                end
                finish = ({1'b0, bir_reg} + 9'd1) >= {1'b0, s_eff};
            end
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        bir_next = bir_reg;
        if (wr_en)
        begin
            col_next = '0;
            row_next = '0;
            bir_next = '0;
        end
        else if (accept)
        begin
            if (finish)
            begin
                col_next = '0;
                bir_next = '0;
                row_next = last_row ? 8'd0 : row_inc[7:0];
            end
            else if (mode_reg == MODE_MONO_STRIDE)
                bir_next = bir_reg + 8'd1;
            else if (mode_reg == MODE_NIBBLE)
                col_next = COL_W'(col_ext + 8'd2);
            else
                col_next = COL_W'(col_ext + 8'd1);
        end
    end

    assign q_push              = accept && (cnt != '0);
    assign q_push_cmd.data     = byte_stream.data_byte;
    assign q_push_cmd.mode     = mode_reg;
    assign q_push_cmd.count    = cnt;
    assign q_push_cmd.row_end  = rend;
    assign q_push_cmd.last_row = last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RST_PIXEL_MODE;
            width_reg  <= RST_GLYPH_WIDTH;
            height_reg <= RST_GLYPH_HEIGHT;
            stride_reg <= RST_ROW_STRIDE;
            col_reg    <= '0;
            row_reg    <= '0;
            bir_reg    <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            bir_reg <= bir_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_PIXEL_MODE:   mode_reg   <= wr_data[1:0];
                    REG_GLYPH_WIDTH:  width_reg  <= wr_data[6:0];
                    REG_GLYPH_HEIGHT: height_reg <= wr_data;
                    REG_ROW_STRIDE:   stride_reg <= wr_data;
                    default:          mode_reg   <= mode_reg;
                endcase
            end
        end
    end

endmodule

// File: rtl/gbu_cmd_queue.sv
// Small command FIFO between the front and back ends.
// Depends on gbu_pkg for the command type.
module gbu_cmd_queue
    import gbu_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = fill_reg == CNT_FULL;
    assign empty   = fill_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: rtl/gbu_back.sv
// Back end: expands a command into registered pixels, one per cycle unless stalled.
// Depends on gbu_pkg and gbu_pixel_if.
module gbu_back
    import gbu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_pop_cmd,
    output logic        q_pop,
    gbu_pixel_if.source pixel_stream
);

    logic             cur_valid_reg, cur_valid_next;
    cmd_t             cur_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       pixel_reg, pixel_next;
    logic             row_end_reg, glyph_end_reg, last_reg;

    logic load;
    logic is_last;

    assign is_last = ({1'b0, idx_reg} + 1'b1) == cur_reg.count;
    assign load    = cur_valid_reg && (!out_valid_reg || pixel_stream.ready);
    assign q_pop   = !q_empty && (!cur_valid_reg || (load && is_last));

    // Pixel value for the current position within the command
    always_comb
    begin
        case (cur_reg.mode)
            MODE_NIBBLE:
                pixel_next = (idx_reg == '0) ? {cur_reg.data[7:4], cur_reg.data[7:4]}
                                             : {cur_reg.data[3:0], cur_reg.data[3:0]};
            MODE_RAW:
                pixel_next = cur_reg.data;
            default:
            begin
                // bit pixels past the first eight of a command are background
                if (idx_reg < IDX_W'(8))
                    pixel_next = cur_reg.data[3'd7 - idx_reg[2:0]] ? 8'd255 : 8'd0;
                else
                    pixel_next = 8'd0;
            end
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (load)
        begin
            if (is_last)
                cur_valid_next = 1'b0;
            idx_next = idx_reg + 1'b1;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (pixel_stream.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_pop_cmd;
        if (load)
        begin
            pixel_reg     <= pixel_next;
            row_end_reg   <= is_last && cur_reg.row_end;
            glyph_end_reg <= is_last && cur_reg.row_end && cur_reg.last_row;
            last_reg      <= is_last;
        end
    end

    assign pixel_stream.valid         = out_valid_reg;
    assign pixel_stream.pixel         = pixel_reg;
    assign pixel_stream.row_end       = row_end_reg;
    assign pixel_stream.glyph_end     = glyph_end_reg;
    assign pixel_stream.last_of_input = last_reg;

endmodule

// File: rtl/gbu_checker.sv
// Port-level checks on the unpacker's pixel stream, bound to the top level.
// Depends on glyph_bitmap_unpacker.
module gbu_port_checks
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] pixel,
    input logic       row_end,
    input logic       glyph_end,
    input logic       last_of_input
);

    // glyph end only ever lands on a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && glyph_end |-> row_end)
        else $error("glyph_end without row_end");

    // a row always closes on the final pixel of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && row_end |-> last_of_input)
        else $error("row_end not on last pixel of byte");

    // output register is empty right after reset
    assert property (@(posedge clk)
        $past(!rst_n) |-> !valid)
        else $error("pixel valid straight out of reset");

    // stalled transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(pixel) && $stable(row_end)
                            && $stable(glyph_end) && $stable(last_of_input))
        else $error("stalled pixel transaction changed");

endmodule

bind glyph_bitmap_unpacker gbu_port_checks u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (pixel_stream.valid),
    .ready        (pixel_stream.ready),
    .pixel        (pixel_stream.pixel),
    .row_end      (pixel_stream.row_end),
    .glyph_end    (pixel_stream.glyph_end),
    .last_of_input(pixel_stream.last_of_input)
);
